// ===== hw/rtl/snpw_pkg.sv =====
package snpw_pkg;

    localparam int SEG_COUNT = 7;
    localparam int DIGIT_W   = 4;
    localparam int VALUE_W   = 16;
    localparam int QUOT_W    = 13;    // 65535 / 10 fits in 13 bits
    localparam int INDEX_W   = 16;
    localparam int COLOR_W   = 32;
    localparam int COUNT_W   = 3;
    localparam int SEG_W     = 3;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [VALUE_W-1:0] DIV10_MUL   = 16'd52429;
    localparam int                 DIV10_SHIFT = 19;

    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEG_COUNT - 1);

    typedef struct packed {
        logic load;     // capture request fields
        logic div;      // register value / 10
        logic digit;    // peel off the low digit, keep the quotient
        logic emit;     // one pixel write into the output register
    } cmd_t;

    typedef struct packed {
        logic count_zero;   // incoming request draws nothing
        logic digit_end;    // current write is the last LED of this digit
        logic pos_last;     // working on digit position 0
        logic out_free;     // output register can take a write
    } status_t;

    // bit 0 = segment a ... bit 6 = segment g
    function automatic logic [SEG_COUNT-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [SEG_COUNT-1:0] pat;
        case (digit)
            4'd0:    pat = 7'b0111111;
            4'd1:    pat = 7'b0000110;
            4'd2:    pat = 7'b1011011;
            4'd3:    pat = 7'b1001111;
            4'd4:    pat = 7'b1100110;
            4'd5:    pat = 7'b1101101;
            4'd6:    pat = 7'b1111101;
            4'd7:    pat = 7'b0000111;
            4'd8:    pat = 7'b1111111;
            4'd9:    pat = 7'b1101111;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

// ===== hw/rtl/snpw_ctrl.sv =====
module snpw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  snpw_pkg::status_t status,
    output snpw_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_DIGIT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (!status.count_zero)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                cmd.digit  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.digit_end)
                    begin
                        state_next = status.pos_last ? ST_IDLE : ST_DIV;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/snpw_datapath.sv =====
module snpw_datapath #(
    parameter int MAX_DIGITS   = 4,
    parameter int LEDS_PER_SEG = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  snpw_pkg::cmd_t                     cmd,
    output snpw_pkg::status_t                  status,
    input  logic [snpw_pkg::INDEX_W-1:0]       start_pixel,
    input  logic [snpw_pkg::COUNT_W-1:0]       digit_count,
    input  logic [snpw_pkg::VALUE_W-1:0]       number_value,
    input  logic [snpw_pkg::COLOR_W-1:0]       lit_color,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [snpw_pkg::INDEX_W-1:0]       pixel_index,
    output logic [snpw_pkg::COLOR_W-1:0]       pixel_color,
    output logic                               last_write
);

    localparam int PER_DIGIT = snpw_pkg::SEG_COUNT * LEDS_PER_SEG;
    localparam int POS_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int LED_W     = (LEDS_PER_SEG > 1) ? $clog2(LEDS_PER_SEG) : 1;
    localparam logic [LED_W-1:0] LED_LAST = LED_W'(LEDS_PER_SEG - 1);
    // after a digit the index sits on its last LED; step back to the next digit's start
    localparam logic [snpw_pkg::INDEX_W-1:0] IDX_BACK =
        snpw_pkg::INDEX_W'(2 * PER_DIGIT - 1);

    logic [snpw_pkg::VALUE_W-1:0] value_reg;
    logic [snpw_pkg::QUOT_W-1:0]  quot_reg;
    logic [snpw_pkg::DIGIT_W-1:0] digit_reg;
    logic [snpw_pkg::COLOR_W-1:0] color_reg;
    logic [snpw_pkg::INDEX_W-1:0] idx_reg;
    logic [POS_W-1:0]             pos_reg;
    logic [snpw_pkg::SEG_W-1:0]   seg_reg;
    logic [LED_W-1:0]             led_reg;

    logic                         out_valid_reg;
    logic [snpw_pkg::INDEX_W-1:0] pixel_index_reg;
    logic [snpw_pkg::COLOR_W-1:0] pixel_color_reg;
    logic                         last_write_reg;

    logic [snpw_pkg::COUNT_W-1:0]   count_sat;
    logic [snpw_pkg::COUNT_W-1:0]   count_m1;
    logic [2*snpw_pkg::VALUE_W-1:0] prod;
    logic [snpw_pkg::VALUE_W-1:0]   quot_x10;
    logic [snpw_pkg::VALUE_W-1:0]   rem;
    logic [snpw_pkg::SEG_COUNT-1:0] pattern;
    logic                           led_end;
    logic                           digit_end;

    assign count_sat = (digit_count > snpw_pkg::COUNT_W'(MAX_DIGITS)) ?
                       snpw_pkg::COUNT_W'(MAX_DIGITS) : digit_count;
    assign count_m1  = count_sat - snpw_pkg::COUNT_W'(1);

    assign prod     = value_reg * snpw_pkg::DIV10_MUL;
    assign quot_x10 = {quot_reg, 3'b000} + {2'b00, quot_reg, 1'b0};
    assign rem      = value_reg - quot_x10;

    assign pattern   = snpw_pkg::seg_pattern(digit_reg);
    assign led_end   = (led_reg == LED_LAST);
    assign digit_end = led_end && (seg_reg == snpw_pkg::SEG_LAST);

    assign status.count_zero = (digit_count == '0);
    assign status.digit_end  = digit_end;
    assign status.pos_last   = (pos_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= number_value;
            color_reg <= lit_color;
            pos_reg   <= POS_W'(count_m1);
            idx_reg   <= start_pixel
                         + snpw_pkg::INDEX_W'(count_m1) * snpw_pkg::INDEX_W'(PER_DIGIT);
            seg_reg   <= '0;
            led_reg   <= '0;
        end
        if (cmd.div)
        begin
            quot_reg <= prod[snpw_pkg::DIV10_SHIFT +: snpw_pkg::QUOT_W];
        end
        if (cmd.digit)
        begin
            digit_reg <= rem[snpw_pkg::DIGIT_W-1:0];
            value_reg <= snpw_pkg::VALUE_W'(quot_reg);
        end
        if (cmd.emit)
        begin
            pixel_index_reg <= idx_reg;
            pixel_color_reg <= pattern[seg_reg] ? color_reg : '0;
            last_write_reg  <= digit_end && (pos_reg == '0);
            if (digit_end)
            begin
                seg_reg <= '0;
                led_reg <= '0;
                pos_reg <= pos_reg - POS_W'(1);
                idx_reg <= idx_reg - IDX_BACK;
            end
            else
            begin
                idx_reg <= idx_reg + snpw_pkg::INDEX_W'(1);
                if (led_end)
                begin
                    led_reg <= '0;
                    seg_reg <= seg_reg + snpw_pkg::SEG_W'(1);
                end
                else
                begin
                    led_reg <= led_reg + LED_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign pixel_color = pixel_color_reg;
    assign last_write  = last_write_reg;

endmodule

// ===== hw/rtl/seven_segment_number_pixel_writer.sv =====
// Seven-segment number pixel writer.
// A request on the s_ channel carries a start pixel, a digit count, a 16-bit
// value and a color. The block draws the low decimal digits of the value,
// leading zeros included, as seven-segment digits on an LED chain: for each
// digit position from the highest down it sends one pixel write per LED
// (7 segments x LEDS_PER_SEG LEDs) on the m_ channel; m_tlast marks the final
// write. Digit counts above MAX_DIGITS saturate; a count of zero sends nothing.
// Each digit runs a divide-by-ten (reciprocal multiply, then remainder),
// then one write per cycle while m_tready stays high. One request is
// worked at a time; s_tready is high only between requests. Writes leave
// through an output register; while m_tready is low the block holds that
// write and pauses. A new request may be taken while the final write
// still waits. Reset empties the output register and returns to idle.
module seven_segment_number_pixel_writer #(
    parameter int MAX_DIGITS   = 4,
    parameter int LEDS_PER_SEG = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // start_pixel[15:0], digit_count[18:16],
                                   // number_value[34:19], lit_color[66:35], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pixel_index[15:0], pixel_color[47:16]
    output logic        m_tlast    // last_write
);

    snpw_pkg::cmd_t    cmd;
    snpw_pkg::status_t status;

    logic [snpw_pkg::INDEX_W-1:0] pixel_index;
    logic [snpw_pkg::COLOR_W-1:0] pixel_color;

    snpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    snpw_datapath #(
        .MAX_DIGITS   (MAX_DIGITS),
        .LEDS_PER_SEG (LEDS_PER_SEG)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_pixel  (s_tdata[15:0]),
        .digit_count  (s_tdata[18:16]),
        .number_value (s_tdata[34:19]),
        .lit_color    (s_tdata[66:35]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel_index  (pixel_index),
        .pixel_color  (pixel_color),
        .last_write   (m_tlast)
    );

    assign m_tdata = {pixel_color, pixel_index};

    // a request that draws something keeps the block busy
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[18:16] != 3'd0) |=> !s_tready)
        else $error("block took a second request while drawing");

    // an empty request leaves the block idle
    a_empty_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[18:16] == 3'd0) |=> s_tready)
        else $error("empty request started a draw");

    // a stalled write stays put until it is taken
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled write changed before it was taken");

    // no write is produced before the divider has run for a new request
    a_no_early_write: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("write produced in the cycle after a request");

endmodule
